// File: hw/rtl/ipv4bl_pkg.sv
`default_nettype none

package ipv4bl_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int CMD_W    = 2;
	localparam int ADDR_W   = 32;
	localparam int STATUS_W = 3;
	localparam int IN_TDATA_W  = ((CMD_W + ADDR_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((STATUS_W + 7) / 8) * 8;

	localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_PASS      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DROP      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
	localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd5;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd6;

	// classified operation handed from front to back
	typedef enum logic [1:0] {
		OP_CHECK  = 2'd0,
		OP_ADD    = 2'd1,
		OP_DELETE = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] address;
	} item_t;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

endpackage

`default_nettype wire

// File: hw/rtl/ipv4bl_ram.sv
`default_nettype none

module ipv4bl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: hw/rtl/ipv4bl_front.sv
`default_nettype none

module ipv4bl_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire logic [ipv4bl_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output ipv4bl_pkg::item_t                        q_item,
	output logic                                     q_valid,
	input  wire logic                                q_pop
);

	ipv4bl_pkg::item_t                      q_mem_q [ipv4bl_pkg::QUEUE_DEPTH];
	logic [ipv4bl_pkg::QPTR_W-1:0]          wr_ptr_q;
	logic [ipv4bl_pkg::QPTR_W-1:0]          rd_ptr_q;
	logic [ipv4bl_pkg::QCNT_W-1:0]          count_q;
	ipv4bl_pkg::item_t                      in_item;
	logic [ipv4bl_pkg::CMD_W-1:0]           in_cmd;
	logic                                   push;
	logic                                   pop;

	assign in_cmd = s_axis_tdata[ipv4bl_pkg::CMD_W-1:0];

	always_comb begin
		in_item.address = s_axis_tdata[ipv4bl_pkg::CMD_W +: ipv4bl_pkg::ADDR_W];
		unique case (in_cmd)
			ipv4bl_pkg::CMD_CHECK:  in_item.op = ipv4bl_pkg::OP_CHECK;
			ipv4bl_pkg::CMD_ADD:    in_item.op = ipv4bl_pkg::OP_ADD;
			ipv4bl_pkg::CMD_DELETE: in_item.op = ipv4bl_pkg::OP_DELETE;
			default:                in_item.op = ipv4bl_pkg::OP_NOP;
		endcase
	end

	assign s_axis_tready = (count_q != ipv4bl_pkg::QCNT_W'(ipv4bl_pkg::QUEUE_DEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign q_valid       = (count_q != '0);
	assign pop           = q_pop && q_valid;
	assign q_item        = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/ipv4bl_back.sv
`default_nettype none

module ipv4bl_back (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire ipv4bl_pkg::item_t                   q_item,
	input  wire logic                                q_valid,
	output logic                                     q_pop,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	output logic [ipv4bl_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_RESP = 3'b100
	} state_t;

	state_t                                 state_q;
	ipv4bl_pkg::op_t                        op_q;
	logic [ipv4bl_pkg::ADDR_W-1:0]          addr_q;
	logic [ipv4bl_pkg::CNT_W-1:0]           rd_cnt_q;
	logic                                   cmp_vld_s1;
	logic [ipv4bl_pkg::IDX_W-1:0]           cmp_idx_s1;
	logic                                   free_found_q;
	logic [ipv4bl_pkg::IDX_W-1:0]           free_idx_q;
	logic [ipv4bl_pkg::TABLE_DEPTH-1:0]     valid_q;
	logic [ipv4bl_pkg::STATUS_W-1:0]        res_status_q;
	logic                                   m_valid_q;
	logic [ipv4bl_pkg::STATUS_W-1:0]        m_status_q;

	logic [ipv4bl_pkg::ADDR_W-1:0]          rdata;
	logic                                   issue;
	logic                                   cur_valid;
	logic                                   hit;
	logic                                   last;
	logic                                   done;
	logic                                   free_now;
	logic [ipv4bl_pkg::IDX_W-1:0]           free_sel;
	logic                                   ram_we;
	logic                                   out_load;
	logic [ipv4bl_pkg::STATUS_W-1:0]        done_status;

	ipv4bl_ram #(
		.WIDTH (ipv4bl_pkg::ADDR_W),
		.DEPTH (ipv4bl_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_sel),
		.wdata (addr_q),
		.raddr (rd_cnt_q[ipv4bl_pkg::IDX_W-1:0]),
		.rdata (rdata)
	);

	assign issue     = (state_q == S_SCAN) &&
	                   (rd_cnt_q < ipv4bl_pkg::CNT_W'(ipv4bl_pkg::TABLE_DEPTH));
	assign cur_valid = valid_q[cmp_idx_s1];
	assign hit       = cmp_vld_s1 && cur_valid && (rdata == addr_q);
	assign last      = (cmp_idx_s1 == ipv4bl_pkg::IDX_W'(ipv4bl_pkg::TABLE_DEPTH - 1));
	assign done      = cmp_vld_s1 && (hit || last);
	// the entry under compare counts as free for the final decision when its valid bit is clear
	assign free_now  = free_found_q || !cur_valid;
	assign free_sel  = free_found_q ? free_idx_q : cmp_idx_s1;
	assign ram_we    = done && (op_q == ipv4bl_pkg::OP_ADD) && !hit && free_now;
	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign out_load  = (state_q == S_RESP) && (!m_valid_q || m_axis_tready);

	always_comb begin
		case (op_q)
			ipv4bl_pkg::OP_CHECK:
				done_status = hit ? ipv4bl_pkg::ST_DROP : ipv4bl_pkg::ST_PASS;
			ipv4bl_pkg::OP_ADD:
				done_status = hit ? ipv4bl_pkg::ST_PRESENT :
				              (free_now ? ipv4bl_pkg::ST_ADDED : ipv4bl_pkg::ST_FULL);
			ipv4bl_pkg::OP_DELETE:
				done_status = hit ? ipv4bl_pkg::ST_REMOVED : ipv4bl_pkg::ST_NOT_FOUND;
			default:
				done_status = ipv4bl_pkg::ST_PASS;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q   <= q_item.op;
			addr_q <= q_item.address;
		end
		cmp_idx_s1 <= rd_cnt_q[ipv4bl_pkg::IDX_W-1:0];
		if (q_pop && (q_item.op == ipv4bl_pkg::OP_NOP)) begin
			res_status_q <= ipv4bl_pkg::ST_PASS;
		end else if (done) begin
			res_status_q <= done_status;
		end
		if (out_load) begin
			m_status_q <= res_status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rd_cnt_q     <= '0;
			cmp_vld_s1   <= 1'b0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			valid_q      <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			cmp_vld_s1 <= issue && !done;
			unique case (state_q)
				S_IDLE: begin
					rd_cnt_q     <= '0;
					free_found_q <= 1'b0;
					if (q_pop) begin
						state_q <= (q_item.op == ipv4bl_pkg::OP_NOP) ? S_RESP : S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (cmp_vld_s1 && !free_found_q && !cur_valid) begin
						free_found_q <= 1'b1;
						free_idx_q   <= cmp_idx_s1;
					end
					if (done) begin
						state_q <= S_RESP;
						if (ram_we) begin
							valid_q[free_sel] <= 1'b1;
						end
						if (hit && (op_q == ipv4bl_pkg::OP_DELETE)) begin
							valid_q[cmp_idx_s1] <= 1'b0;
						end
					end
				end
				S_RESP: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(ipv4bl_pkg::OUT_TDATA_W - ipv4bl_pkg::STATUS_W){1'b0}},
	                        m_status_q};

	a_cmp_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_s1 |-> (state_q == S_SCAN))
		else $error("compare stage active outside scan");

	a_write_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (done && (state_q == S_SCAN) && (op_q == ipv4bl_pkg::OP_ADD)))
		else $error("table write outside add completion");

	a_add_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> valid_q[$past(free_sel)])
		else $error("added entry not marked valid");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_cnt_q <= ipv4bl_pkg::CNT_W'(ipv4bl_pkg::TABLE_DEPTH))
		else $error("scan counter past table depth");

	a_load_resp: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (m_valid_q && (state_q == S_IDLE)))
		else $error("result load did not return to idle");

endmodule

`default_nettype wire

// File: hw/rtl/ipv4_destination_blacklist_top.sv
// IPv4 destination blacklist.
// Input stream s_axis: one transfer per command (check packet, add address,
// delete address). Output stream m_axis: exactly one status transfer per
// input transfer, in order.
// The front end takes transfers into a two-entry queue and decodes the
// command; the back end scans the 64-entry address memory one entry per
// cycle through its single registered read port, comparing against entries
// whose valid bit is set and tracking the lowest free entry.
// A miss or a full scan reads every entry, while a hit ends the scan early;
// an unknown command skips the scan and answers pass. The back end takes
// one item at a time and pops the next from the queue only in its idle state.
// Reset clears all valid bits, the queue and the output valid flag; the
// address memory is not cleared and needs no clearing pass.
// When m_axis_tready is low the status is held in the output register; the
// back end finishes the next scan and waits, while the queue still accepts
// up to two more transfers before s_axis_tready drops.
`default_nettype none

module ipv4_destination_blacklist_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// [1:0] command, [33:2] address, [39:34] zero
	input  wire logic [ipv4bl_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// [2:0] status, [7:3] zero
	output logic [ipv4bl_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

	ipv4bl_pkg::item_t q_item;
	logic              q_valid;
	logic              q_pop;

	ipv4bl_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.q_item        (q_item),
		.q_valid       (q_valid),
		.q_pop         (q_pop)
	);

	ipv4bl_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_item        (q_item),
		.q_valid       (q_valid),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

`default_nettype wire
